### design/mtkct_pkg.sv
// Shared types and codes for the magnitude top-k coefficient tiering block.
// Used by all design modules except mtkct_ram; no dependencies.
package mtkct_pkg;

    localparam int LEN_W   = 11;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int CFG_TIERS = 4;

    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        t_len                      coeff_count;
        t_len                      approx_count;
        logic [CFG_TIERS-1:0][LEN_W-1:0] tier_len;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_KEPT       = 2'd0,
        ST_DONE       = 2'd1,
        ST_NOT_LOADED = 2'd2,
        ST_BAD_CFG    = 2'd3
    } t_status;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [2:0] {
        REG_COEFF_COUNT    = 3'd0,
        REG_APPROX_COUNT   = 3'd1,
        REG_TIER_LEN_ZERO  = 3'd2,
        REG_TIER_LEN_ONE   = 3'd3,
        REG_TIER_LEN_TWO   = 3'd4,
        REG_TIER_LEN_THREE = 3'd5
    } t_reg_idx;

endpackage

### design/mtkct_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mtkct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mtkct_front.sv
// Front end: accepts input transfers and queues them, tagged load or fetch.
// Depends on mtkct_pkg.
module mtkct_front
    import mtkct_pkg::*;
#(
    parameter int COEFF_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_operation,
    input  logic [COEFF_WIDTH-1:0] i_coeff_value,
    output logic                   o_q_valid,
    output logic                   o_q_op,
    output logic [COEFF_WIDTH-1:0] o_q_value,
    input  logic                   i_q_pop
);

    logic                   r_op  [2];
    logic [COEFF_WIDTH-1:0] r_val [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   w_push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_op     = r_op[r_rp];
    assign o_q_value  = r_val[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wp]  <= (i_operation == OP_FETCH);
            r_val[r_wp] <= i_coeff_value;
        end
    end

endmodule

### design/mtkct_back.sv
// Back end: loads the frame, ranks by magnitude, builds the fetch list, answers fetches.
// Depends on mtkct_pkg and mtkct_ram.
module mtkct_back
    import mtkct_pkg::*;
#(
    parameter int MAX_COEFFS  = 1024,
    parameter int NUM_TIERS   = 4,
    parameter int COEFF_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  logic                   i_q_op,
    input  logic [COEFF_WIDTH-1:0] i_q_value,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [((NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1)-1:0] o_tier,
    output logic [$clog2(MAX_COEFFS)-1:0] o_position,
    output logic [COEFF_WIDTH-1:0] o_kept_value,
    output logic                   o_last_in_tier,
    output logic                   o_last
);

    localparam int AW   = $clog2(MAX_COEFFS);
    localparam int CW   = $clog2(MAX_COEFFS + 1);
    localparam int TW   = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
    localparam int TGW  = TW + 1;
    localparam int SUMW = LEN_W + 3;
    localparam int XW   = ((SUMW > CW) ? SUMW : CW) + 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RK_RD   = 8'b0000_0010,
        S_RK_WAIT = 8'b0000_0100,
        S_RK_SCAN = 8'b0000_1000,
        S_RK_TAG  = 8'b0001_0000,
        S_SWEEP   = 8'b0010_0000,
        S_F_POS   = 8'b0100_0000,
        S_F_VAL   = 8'b1000_0000
    } t_state;

    function automatic logic [COEFF_WIDTH-1:0] f_mag(input logic [COEFF_WIDTH-1:0] v);
        return v[COEFF_WIDTH-1] ? (~v + COEFF_WIDTH'(1)) : v;
    endfunction

    t_state r_state, n_state;
    logic [CW-1:0]   r_load_cnt, n_load_cnt;
    logic            r_ready, n_ready, r_bad, n_bad;
    logic [CW-1:0]   r_n, n_n;
    t_len            r_approx, n_approx;
    logic [SUMW-1:0] r_cum [NUM_TIERS];
    logic [SUMW-1:0] n_cum [NUM_TIERS];
    logic [SUMW-1:0] w_cum [NUM_TIERS];
    logic [CW-1:0]   r_i, n_i, r_j, n_j, r_jd, n_jd, r_rank, n_rank;
    logic            r_jv, n_jv;
    logic [COEFF_WIDTH-1:0] r_mi, n_mi;
    logic [CW-1:0]   r_sp, n_sp, r_pd, n_pd, r_lk, n_lk, r_fk, n_fk;
    logic [TW-1:0]   r_st, n_st, r_pt, n_pt;
    logic            r_sact, n_sact, r_pv, n_pv;
    logic [AW-1:0]   r_fpos, n_fpos;

    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    logic [TW-1:0]   r_tier, n_tier;
    logic [AW-1:0]   r_pos, n_pos;
    logic [COEFF_WIDTH-1:0] r_kept, n_kept;
    logic            r_lit, n_lit, r_last, n_last;

    logic [CW-1:0]   w_eff;
    logic            w_bad, w_out_free;
    logic [TGW-1:0]  w_rank_tag;
    logic [TW-1:0]   w_ftier;
    logic            w_flit, w_found_f, w_found_r;
    logic [COEFF_WIDTH-1:0] w_mj;
    logic            w_kept;

    logic                   c_we, c_re, t_we, t_re, l_we, l_re;
    logic [AW-1:0]          c_waddr, c_raddr, t_waddr, t_raddr, l_waddr, l_raddr;
    logic [COEFF_WIDTH-1:0] c_wdata, c_rdata;
    logic [TGW-1:0]         t_wdata, t_rdata;
    logic [AW-1:0]          l_wdata, l_rdata;

    mtkct_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(MAX_COEFFS)) u_coeff_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    mtkct_ram #(.WIDTH(TGW), .DEPTH(MAX_COEFFS)) u_tag_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_re(t_re), .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    mtkct_ram #(.WIDTH(AW), .DEPTH(MAX_COEFFS)) u_list_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_re(l_re), .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    // frame length, cumulative tier bounds and configuration check
    always_comb begin
        if (i_cfg.coeff_count == '0) begin
            w_eff = CW'(1);
        end else if (XW'(i_cfg.coeff_count) > XW'(MAX_COEFFS)) begin
            w_eff = CW'(MAX_COEFFS);
        end else begin
            w_eff = CW'(i_cfg.coeff_count);
        end
        for (int t = 0; t < NUM_TIERS; t++) begin
            w_cum[t] = ((t > 0) ? w_cum[(t > 0) ? t - 1 : 0] : '0)
                     + ((t < CFG_TIERS) ? SUMW'(i_cfg.tier_len[t[1:0]]) : '0);
        end
        w_bad = (i_cfg.approx_count > i_cfg.tier_len[0])
             || (XW'(w_cum[NUM_TIERS-1]) > XW'(w_eff));
    end

    // tier of the current rank, and tier flags of the current fetch index
    always_comb begin
        w_rank_tag = {1'b1, {TW{1'b0}}};
        w_found_r  = 1'b0;
        w_ftier    = '0;
        w_flit     = 1'b0;
        w_found_f  = 1'b0;
        for (int t = 0; t < NUM_TIERS; t++) begin
            if (!w_found_r && (XW'(r_rank) + XW'(r_approx) < XW'(r_cum[t]))) begin
                w_found_r  = 1'b1;
                w_rank_tag = {1'b0, TW'(t)};
            end
            if (!w_found_f && (XW'(r_fk) < XW'(r_cum[t]))) begin
                w_found_f = 1'b1;
                w_ftier   = TW'(t);
                w_flit    = (XW'(r_fk) + XW'(1) == XW'(r_cum[t]));
            end
        end
    end

    assign w_mj       = f_mag(c_rdata);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_kept     = (XW'(r_pd) < XW'(r_approx)) ? (r_pt == '0)
                                                    : (t_rdata == {1'b0, r_pt});

    always_comb begin
        n_state = r_state;   n_load_cnt = r_load_cnt; n_ready = r_ready;
        n_bad = r_bad;       n_n = r_n;               n_approx = r_approx;
        n_cum = r_cum;       n_i = r_i;               n_j = r_j;
        n_jd = r_jd;         n_jv = r_jv;             n_rank = r_rank;
        n_mi = r_mi;         n_sp = r_sp;             n_st = r_st;
        n_pd = r_pd;         n_pt = r_pt;             n_sact = r_sact;
        n_pv = r_pv;         n_lk = r_lk;             n_fk = r_fk;
        n_fpos = r_fpos;
        n_out_valid = r_out_valid && i_out_stall;
        n_status = r_status; n_tier = r_tier;         n_pos = r_pos;
        n_kept = r_kept;     n_lit = r_lit;           n_last = r_last;
        o_q_pop = 1'b0;
        c_we = 1'b0; c_waddr = r_load_cnt[AW-1:0]; c_wdata = i_q_value;
        c_re = 1'b0; c_raddr = r_i[AW-1:0];
        t_we = 1'b0; t_waddr = r_i[AW-1:0]; t_wdata = w_rank_tag;
        t_re = 1'b0; t_raddr = r_sp[AW-1:0];
        l_we = 1'b0; l_waddr = r_lk[AW-1:0]; l_wdata = r_pd[AW-1:0];
        l_re = 1'b0; l_raddr = r_fk[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && (i_q_op == OP_LOAD)) begin
                    o_q_pop = 1'b1;
                    c_we    = 1'b1;
                    n_ready = 1'b0;
                    if (XW'(r_load_cnt) + XW'(1) >= XW'(w_eff)) begin
                        n_load_cnt = '0;
                        n_n        = w_eff;
                        n_approx   = i_cfg.approx_count;
                        n_cum      = w_cum;
                        n_bad      = w_bad;
                        n_fk       = '0;
                        if (w_bad) begin
                            n_ready = 1'b1;
                        end else begin
                            n_i     = CW'(i_cfg.approx_count);
                            n_state = S_RK_RD;
                        end
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end else if (i_q_valid && w_out_free) begin
                    o_q_pop  = 1'b1;
                    n_tier   = '0;
                    n_pos    = '0;
                    n_kept   = '0;
                    n_lit    = 1'b0;
                    n_last   = 1'b0;
                    if (!r_ready) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NOT_LOADED;
                    end else if (r_bad) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_BAD_CFG;
                    end else if (XW'(r_fk) >= XW'(r_cum[NUM_TIERS-1])) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_DONE;
                    end else begin
                        l_re    = 1'b1;
                        n_state = S_F_POS;
                    end
                end
            end
            S_RK_RD: begin
                if (XW'(r_i) >= XW'(r_n)) begin
                    n_sact  = 1'b1;
                    n_sp    = '0;
                    n_st    = '0;
                    n_pv    = 1'b0;
                    n_lk    = '0;
                    n_state = S_SWEEP;
                end else begin
                    c_re    = 1'b1;
                    n_state = S_RK_WAIT;
                end
            end
            S_RK_WAIT: begin
                n_mi    = f_mag(c_rdata);
                n_j     = CW'(r_approx);
                n_rank  = '0;
                n_jv    = 1'b0;
                n_state = S_RK_SCAN;
            end
            S_RK_SCAN: begin
                n_jv = 1'b0;
                if (XW'(r_j) < XW'(r_n)) begin
                    c_re    = 1'b1;
                    c_raddr = r_j[AW-1:0];
                    n_jv    = 1'b1;
                    n_jd    = r_j;
                    n_j     = r_j + 1'b1;
                end
                if (r_jv && ((w_mj > r_mi) || ((w_mj == r_mi) && (r_jd < r_i)))) begin
                    n_rank = r_rank + 1'b1;
                end
                if (!(XW'(r_j) < XW'(r_n)) && !r_jv) begin
                    n_state = S_RK_TAG;
                end
            end
            S_RK_TAG: begin
                t_we    = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_RK_RD;
            end
            S_SWEEP: begin
                n_pv = 1'b0;
                if (r_sact) begin
                    t_re = 1'b1;
                    n_pv = 1'b1;
                    n_pd = r_sp;
                    n_pt = r_st;
                    if (XW'(r_sp) + XW'(1) >= XW'(r_n)) begin
                        n_sp = '0;
                        if (XW'(r_st) == XW'(NUM_TIERS - 1)) begin
                            n_sact = 1'b0;
                        end else begin
                            n_st = r_st + 1'b1;
                        end
                    end else begin
                        n_sp = r_sp + 1'b1;
                    end
                end
                if (r_pv && w_kept) begin
                    l_we = 1'b1;
                    n_lk = r_lk + 1'b1;
                end
                if (!r_sact && !r_pv) begin
                    n_ready = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_F_POS: begin
                c_re    = 1'b1;
                c_raddr = l_rdata;
                n_fpos  = l_rdata;
                n_state = S_F_VAL;
            end
            S_F_VAL: begin
                n_out_valid = 1'b1;
                n_status    = ST_KEPT;
                n_tier      = w_ftier;
                n_pos       = r_fpos;
                n_kept      = c_rdata;
                n_lit       = w_flit;
                n_last      = (XW'(r_fk) + XW'(1) == XW'(r_cum[NUM_TIERS-1]));
                n_fk        = r_fk + 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_cnt  <= '0;
            r_ready     <= 1'b0;
            r_bad       <= 1'b0;
            r_jv        <= 1'b0;
            r_sact      <= 1'b0;
            r_pv        <= 1'b0;
            r_fk        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_ready     <= n_ready;
            r_bad       <= n_bad;
            r_jv        <= n_jv;
            r_sact      <= n_sact;
            r_pv        <= n_pv;
            r_fk        <= n_fk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_approx <= n_approx;
        r_cum    <= n_cum;
        r_i      <= n_i;
        r_j      <= n_j;
        r_jd     <= n_jd;
        r_rank   <= n_rank;
        r_mi     <= n_mi;
        r_sp     <= n_sp;
        r_st     <= n_st;
        r_pd     <= n_pd;
        r_pt     <= n_pt;
        r_lk     <= n_lk;
        r_fpos   <= n_fpos;
        r_status <= n_status;
        r_tier   <= n_tier;
        r_pos    <= n_pos;
        r_kept   <= n_kept;
        r_lit    <= n_lit;
        r_last   <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_tier         = r_tier;
    assign o_position     = r_pos;
    assign o_kept_value   = r_kept;
    assign o_last_in_tier = r_lit;
    assign o_last         = r_last;

endmodule

### design/magnitude_topk_coefficient_tiering.sv
// Top level: configuration registers, front queue and ranking/fetch back end.
// Depends on mtkct_pkg, mtkct_front, mtkct_back.
//
//  port group   direction  handshake                  payload
//  in           sink       i_in_valid / o_in_stall    i_operation, i_coeff_value
//  out          source     o_out_valid / i_out_stall  o_status .. o_last
//  apb          sink       psel, penable, pready      paddr, pwrite, pwdata, prdata
//
// Load: the back end pops the queue and writes the coefficient RAM. Fetch: queue pop,
// list read, coefficient read; status-only replies are registered at the queue pop.
// Ranking runs after the last load of a frame through the single read port of the
// coefficient RAM; input stalls once the queue fills.
// Reset is synchronous; the RAMs need no clearing pass.
module magnitude_topk_coefficient_tiering
    import mtkct_pkg::*;
#(
    parameter int MAX_COEFFS  = 1024,
    parameter int NUM_TIERS   = 4,
    parameter int COEFF_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_operation,
    input  logic [COEFF_WIDTH-1:0] i_coeff_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [((NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1)-1:0] o_tier,
    output logic [$clog2(MAX_COEFFS)-1:0] o_position,
    output logic [COEFF_WIDTH-1:0] o_kept_value,
    output logic                   o_last_in_tier,
    output logic                   o_last,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cfg                   r_cfg;
    logic                   w_q_valid, w_q_op, w_q_pop;
    logic [COEFF_WIDTH-1:0] w_q_value;
    t_reg_idx               w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_count  <= t_len'(1024);
            r_cfg.approx_count <= '0;
            r_cfg.tier_len     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_COEFF_COUNT:    r_cfg.coeff_count  <= pwdata[LEN_W-1:0];
                REG_APPROX_COUNT:   r_cfg.approx_count <= pwdata[LEN_W-1:0];
                REG_TIER_LEN_ZERO:  r_cfg.tier_len[0]  <= pwdata[LEN_W-1:0];
                REG_TIER_LEN_ONE:   r_cfg.tier_len[1]  <= pwdata[LEN_W-1:0];
                REG_TIER_LEN_TWO:   r_cfg.tier_len[2]  <= pwdata[LEN_W-1:0];
                REG_TIER_LEN_THREE: r_cfg.tier_len[3]  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COEFF_COUNT:    prdata = APB_DW'(r_cfg.coeff_count);
            REG_APPROX_COUNT:   prdata = APB_DW'(r_cfg.approx_count);
            REG_TIER_LEN_ZERO:  prdata = APB_DW'(r_cfg.tier_len[0]);
            REG_TIER_LEN_ONE:   prdata = APB_DW'(r_cfg.tier_len[1]);
            REG_TIER_LEN_TWO:   prdata = APB_DW'(r_cfg.tier_len[2]);
            REG_TIER_LEN_THREE: prdata = APB_DW'(r_cfg.tier_len[3]);
            default:            prdata = '0;
        endcase
    end

    mtkct_front #(.COEFF_WIDTH(COEFF_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_coeff_value (i_coeff_value),
        .o_q_valid     (w_q_valid),
        .o_q_op        (w_q_op),
        .o_q_value     (w_q_value),
        .i_q_pop       (w_q_pop)
    );

    mtkct_back #(
        .MAX_COEFFS  (MAX_COEFFS),
        .NUM_TIERS   (NUM_TIERS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_op         (w_q_op),
        .i_q_value      (w_q_value),
        .o_q_pop        (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_tier         (o_tier),
        .o_position     (o_position),
        .o_kept_value   (o_kept_value),
        .o_last_in_tier (o_last_in_tier),
        .o_last         (o_last)
    );

endmodule

### design/mtkct_checker.sv
// Port-level checks for magnitude_topk_coefficient_tiering, bound to the top level.
// Depends on mtkct_pkg.
module mtkct_checker
    import mtkct_pkg::*;
#(
    parameter int MAX_COEFFS  = 1024,
    parameter int NUM_TIERS   = 4,
    parameter int COEFF_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [1:0]             o_status,
    input logic [((NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1)-1:0] o_tier,
    input logic [$clog2(MAX_COEFFS)-1:0] o_position,
    input logic [COEFF_WIDTH-1:0] o_kept_value,
    input logic                   o_last_in_tier,
    input logic                   o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_position)
                                       && $stable(o_kept_value) && $stable(o_tier))
        else $error("result changed under stall");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_KEPT) |-> (o_tier == '0) && (o_position == '0)
            && (o_kept_value == '0) && !o_last_in_tier && !o_last)
        else $error("fields not cleared on status reply");

    a_last_ends_tier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_last_in_tier && (o_status == ST_KEPT))
        else $error("frame end without tier end");

endmodule

bind magnitude_topk_coefficient_tiering mtkct_checker #(
    .MAX_COEFFS  (MAX_COEFFS),
    .NUM_TIERS   (NUM_TIERS),
    .COEFF_WIDTH (COEFF_WIDTH)
) u_mtkct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_tier         (o_tier),
    .o_position     (o_position),
    .o_kept_value   (o_kept_value),
    .o_last_in_tier (o_last_in_tier),
    .o_last         (o_last)
);
